[rtl/core/csm_pkg.sv]
// Shared constants, types and helper functions of the case-insensitive substring matcher.
package csm_pkg;

  localparam int MAX_NEEDLE = 16;
  localparam int REG_BYTES = 16;
  localparam int ACT_MAX = (MAX_NEEDLE < REG_BYTES) ? MAX_NEEDLE : REG_BYTES;
  localparam int CW = $clog2(MAX_NEEDLE + 1);
  localparam int LW = $clog2(ACT_MAX + 1);
  localparam int CFG_DW = 64;
  localparam int CFG_IW = 2;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_NEEDLE_LOW = 2'd0,
    REG_NEEDLE_HIGH = 2'd1,
    REG_NEEDLE_LENGTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    byte_t text_byte;
    logic end_of_text;
  } item_t;

  typedef struct packed {
    logic [63:0] low_bytes;
    logic [63:0] high_bytes;
    logic [4:0] length;
  } needle_t;

  function automatic byte_t fold_case(byte_t c);
    return (c >= 8'h41 && c <= 8'h5A) ? byte_t'(c + 8'h20) : c;
  endfunction

  function automatic byte_t needle_byte(needle_t n, int unsigned j);
    logic [2:0] sel;
    byte_t b;
    sel = j[2:0];
    if (j < 8) begin
      b = n.low_bytes[8*sel +: 8];
    end else if (j < REG_BYTES) begin
      b = n.high_bytes[8*sel +: 8];
    end else begin
      b = 8'h00;
    end
    return b;
  endfunction

endpackage

[rtl/core/csm_config.sv]
// Configuration registers holding the needle bytes and the needle length.
module csm_config
  import csm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output needle_t           needle
);

  always_ff @(posedge clk) begin
    if (rst) begin
      needle <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NEEDLE_LOW: begin
          needle.low_bytes <= cfg_data[63:0];
        end
        REG_NEEDLE_HIGH: begin
          needle.high_bytes <= cfg_data[63:0];
        end
        REG_NEEDLE_LENGTH: begin
          needle.length <= cfg_data[4:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/csm_in_reg.sv]
// Input register stage that holds one accepted transaction until the match stage takes it.
module csm_in_reg
  import csm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t text_byte,
  input  logic  end_of_text,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.text_byte <= text_byte;
      item.end_of_text <= end_of_text;
    end
  end

endmodule

[rtl/core/csm_match.sv]
// Folded byte window, parallel needle compare, found flag and result register.
module csm_match
  import csm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_take,
  input  needle_t needle,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    found
);

  byte_t window [MAX_NEEDLE];
  byte_t window_next [MAX_NEEDLE];
  logic [CW-1:0] bytes_seen;
  logic [CW-1:0] bytes_seen_next;
  logic found_flag;
  logic found_flag_next;
  logic [4:0] len_clamp;
  logic [LW-1:0] act_len;
  byte_t needle_fold [ACT_MAX];
  logic [ACT_MAX:0] match_at;
  logic hit;
  logic end_take;

  assign item_take = item_valid && (!item.end_of_text || !out_valid || out_ready);
  assign end_take = item_take && item.end_of_text;

  assign len_clamp = (needle.length > 5'(ACT_MAX)) ? 5'(ACT_MAX) : needle.length;
  assign act_len = len_clamp[LW-1:0];

  always_comb begin
    for (int j = 0; j < ACT_MAX; j++) begin
      needle_fold[j] = fold_case(needle_byte(needle, j));
    end
  end

  always_comb begin
    window_next[0] = fold_case(item.text_byte);
    for (int i = 1; i < MAX_NEEDLE; i++) begin
      window_next[i] = window[i-1];
    end
  end

  always_comb begin
    logic m;
    match_at[0] = 1'b0;
    for (int l = 1; l <= ACT_MAX; l++) begin
      m = 1'b1;
      for (int j = 0; j < ACT_MAX; j++) begin
        if (j < l) begin
          m = m && (window_next[l-1-j] == needle_fold[j]);
        end
      end
      match_at[l] = m;
    end
  end

  always_comb begin
    if (bytes_seen == CW'(MAX_NEEDLE)) begin
      bytes_seen_next = bytes_seen;
    end else begin
      bytes_seen_next = bytes_seen + CW'(1);
    end
  end

  assign hit = match_at[act_len] && (bytes_seen_next >= CW'(act_len));
  assign found_flag_next = found_flag || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_NEEDLE; i++) begin
        window[i] <= '0;
      end
      bytes_seen <= '0;
      found_flag <= 1'b0;
    end else if (item_take) begin
      if (item.end_of_text) begin
        for (int i = 0; i < MAX_NEEDLE; i++) begin
          window[i] <= '0;
        end
        bytes_seen <= '0;
        found_flag <= 1'b0;
      end else begin
        window <= window_next;
        bytes_seen <= bytes_seen_next;
        found_flag <= found_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (end_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_take) begin
      found <= found_flag || (act_len == '0);
    end
  end

`ifndef ASSERT_OFF
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    end_take |=> out_valid)
    else $error("End of text did not load the result register.");

  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    end_take |=> (bytes_seen == '0) && !found_flag)
    else $error("End of text did not clear the count and flag.");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= CW'(MAX_NEEDLE))
    else $error("Byte count exceeded the window depth.");

  a_flag_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(found_flag) |-> $past(item_take && !item.end_of_text))
    else $error("Found flag rose without a text byte.");
`endif

endmodule

[rtl/core/case_insensitive_substring_match_top.sv]
// Top level of the case-insensitive substring matcher.
//
// Text bytes arrive on the input channel (in_valid, in_ready, text_byte,
// end_of_text); one transaction carries one byte, or marks the end of text.
// Each byte is case folded and shifted into a window, and a parallel compare
// against the needle sets a found flag. An end-of-text transaction produces
// one transaction on the output channel (out_valid, out_ready, found) and
// clears the window, the byte count and the flag.
// The needle is written through cfg_write, cfg_index and cfg_data while the
// block is idle: index 0 holds bytes 0 to 7, index 1 bytes 8 to 15, index 2
// the length. A zero length matches every text.
// Throughput is one transaction per cycle, set by the combinational window
// compare. A result is registered as its end-of-text transaction leaves the
// input register. While the output register is full and not taken, text
// bytes keep flowing; only the next end-of-text transaction waits in the
// input register, and with it the input channel.
// A synchronous reset clears the needle, the window, the count, the flag and
// both valid bits.
module case_insensitive_substring_match_top
  import csm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        text_byte,
  input  logic              end_of_text,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  needle_t needle;
  item_t item;
  logic item_valid;
  logic item_take;

  csm_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .needle    (needle)
  );

  csm_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  csm_match u_match (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .needle     (needle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found)
  );

endmodule
